>>> hdl/decimal_token_to_hex_rewriter_macros.svh
// Assertion macros for the decimal token rewriter.
`ifndef DECIMAL_TOKEN_TO_HEX_REWRITER_MACROS_SVH
`define DECIMAL_TOKEN_TO_HEX_REWRITER_MACROS_SVH
`ifndef SYNTH
`define DTHR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DTHR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DTHR_ASSERT_IMP(label, ante, cons, msg)
`define DTHR_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> hdl/dthr_pkg.sv
`timescale 1ns / 1ps
package dthr_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef logic [3:0] upc_t;

  localparam upc_t PC_IDLE  = 4'd0;
  localparam upc_t PC_CHECK = 4'd1;
  localparam upc_t PC_SPACE = 4'd2;
  localparam upc_t PC_TRD   = 4'd3;
  localparam upc_t PC_TEM   = 4'd4;
  localparam upc_t PC_SIGN  = 4'd5;
  localparam upc_t PC_ZERO  = 4'd6;
  localparam upc_t PC_X     = 4'd7;
  localparam upc_t PC_SKIP  = 4'd8;
  localparam upc_t PC_DIGIT = 4'd9;
  localparam upc_t PC_FIN   = 4'd10;

  typedef enum logic [2:0] {
    EM_NONE, EM_SPACE, EM_MINUS, EM_ZERO, EM_X, EM_RAM, EM_HEX, EM_MARK
  } emit_sel_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_ACCEPT, OP_PREP, OP_READ, OP_TEXT, OP_SKIP, OP_DIGIT, OP_FIN
  } op_t;

  typedef enum logic [2:0] {
    JC_NEVER, JC_ALWAYS, JC_FLUSH, JC_EMPTY, JC_NUMERIC, JC_TEXT_END, JC_HEX_START,
    JC_NIB_END
  } jcond_t;

  // hold: stay on this step when the jump is not taken
  typedef struct packed {
    logic      rdy;
    logic      hold;
    emit_sel_t em;
    op_t       op;
    jcond_t    jc;
    upc_t      tgt;
  } ucode_t;

  function automatic ucode_t ucode_rom(input upc_t pc);
    ucode_t w;
    unique case (pc)
      PC_IDLE:  w = '{1'b1, 1'b1, EM_NONE,  OP_ACCEPT, JC_FLUSH,     PC_CHECK};
      PC_CHECK: w = '{1'b0, 1'b0, EM_NONE,  OP_PREP,   JC_EMPTY,     PC_FIN};
      PC_SPACE: w = '{1'b0, 1'b0, EM_SPACE, OP_NONE,   JC_NUMERIC,   PC_SIGN};
      PC_TRD:   w = '{1'b0, 1'b0, EM_NONE,  OP_READ,   JC_NEVER,     PC_IDLE};
      PC_TEM:   w = '{1'b0, 1'b1, EM_RAM,   OP_TEXT,   JC_TEXT_END,  PC_FIN};
      PC_SIGN:  w = '{1'b0, 1'b0, EM_MINUS, OP_NONE,   JC_NEVER,     PC_IDLE};
      PC_ZERO:  w = '{1'b0, 1'b0, EM_ZERO,  OP_NONE,   JC_NEVER,     PC_IDLE};
      PC_X:     w = '{1'b0, 1'b0, EM_X,     OP_NONE,   JC_NEVER,     PC_IDLE};
      PC_SKIP:  w = '{1'b0, 1'b1, EM_NONE,  OP_SKIP,   JC_HEX_START, PC_DIGIT};
      PC_DIGIT: w = '{1'b0, 1'b1, EM_HEX,   OP_DIGIT,  JC_NIB_END,   PC_FIN};
      PC_FIN:   w = '{1'b0, 1'b0, EM_MARK,  OP_FIN,    JC_ALWAYS,    PC_IDLE};
      default:  w = '{1'b0, 1'b0, EM_NONE,  OP_NONE,   JC_ALWAYS,    PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'h0, d};
    end else begin
      c = CH_UA + {4'h0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

>>> hdl/dthr_ram.sv
`timescale 1ns / 1ps
module dthr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/decimal_token_to_hex_rewriter.sv
`timescale 1ns / 1ps
// channel  | ports                                              | role
// ---------+----------------------------------------------------+---------------------
// in       | in_valid, in_ready, in_char, in_last               | line characters
// out      | out_valid, out_ready, out_char, out_valid_char,    | rewritten line
//          | out_last, out_word_truncated                       |
//
// A word character is taken on the idle step; in_ready is high only on that step.
// A delimiter or line end runs the flush program: a check step; if the word is not
// empty, a space step, then a buffer read and the text chars, or the sign, the 0x
// prefix, a skip of leading zero nibbles and the hex digits; then a finish step.
// Sync reset clears the step counter, word state and output valid flag.
// A full output register that is not taken holds any step that emits.
`include "decimal_token_to_hex_rewriter_macros.svh"
module decimal_token_to_hex_rewriter #(
  parameter int MAX_WORD   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_valid_char,
  output logic       out_last,
  output logic       out_word_truncated
);

  localparam int AW    = $clog2(MAX_WORD);
  localparam int LEN_W = $clog2(MAX_WORD + 1);
  localparam int NIBS  = (VALUE_BITS + 3) / 4;
  localparam int SH_W  = NIBS * 4;
  localparam int NIB_W = $clog2(NIBS);

  dthr_pkg::upc_t   pc_r, pc_nxt;
  dthr_pkg::ucode_t uc;

  logic [LEN_W-1:0]      len_r, len_nxt;
  logic                  alld_r, alld_nxt;
  logic                  neg_r, neg_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                  first_r, first_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  last_r, last_nxt;
  logic                  numeric_r, numeric_nxt;
  logic [SH_W-1:0]       sh_r, sh_nxt;
  logic [NIB_W-1:0]      nib_r, nib_nxt;
  logic [LEN_W-1:0]      rd_idx_r, rd_idx_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_vc_r, out_vc_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_trunc_r, out_trunc_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  logic       delim_in, in_fire, empty, text_end, nib_zero, hex_start;
  logic [3:0] top_nib;
  logic       emit_en, out_free, go, jc_true;
  logic [7:0] em_char;
  logic       em_last, em_vc, em_trunc;

  dthr_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_char),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign uc        = dthr_pkg::ucode_rom(pc_r);
  assign in_ready  = uc.rdy;
  assign in_fire   = in_valid && uc.rdy;
  assign delim_in  = (in_char == dthr_pkg::CH_SPACE) || (in_char == dthr_pkg::CH_TAB);
  assign empty     = (len_r == '0);
  assign text_end  = (rd_idx_r == len_r);
  assign top_nib   = sh_r[SH_W-1 -: 4];
  assign nib_zero  = (nib_r == '0);
  assign hex_start = (top_nib != 4'h0) || nib_zero;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    unique case (uc.em)
      dthr_pkg::EM_NONE:  emit_en = 1'b0;
      dthr_pkg::EM_SPACE: emit_en = !first_r;
      dthr_pkg::EM_MINUS: emit_en = neg_r;
      dthr_pkg::EM_MARK:  emit_en = last_r && empty;
      default:            emit_en = 1'b1;
    endcase
  end

  assign go = !emit_en || out_free;

  always_comb begin
    em_last = 1'b0;
    em_vc   = 1'b1;
    unique case (uc.em)
      dthr_pkg::EM_SPACE: em_char = dthr_pkg::CH_SPACE;
      dthr_pkg::EM_MINUS: em_char = dthr_pkg::CH_MINUS;
      dthr_pkg::EM_ZERO:  em_char = dthr_pkg::CH_ZERO;
      dthr_pkg::EM_X:     em_char = dthr_pkg::CH_X;
      dthr_pkg::EM_RAM: begin
        em_char = ram_rdata;
        em_last = last_r && text_end;
      end
      dthr_pkg::EM_HEX: begin
        em_char = dthr_pkg::hex_char(top_nib);
        em_last = last_r && nib_zero;
      end
      dthr_pkg::EM_MARK: begin
        em_char = dthr_pkg::CH_NUL;
        em_last = 1'b1;
        em_vc   = 1'b0;
      end
      default: em_char = dthr_pkg::CH_NUL;
    endcase
    em_trunc = !numeric_r && ovf_r &&
               ((uc.em == dthr_pkg::EM_SPACE) || (uc.em == dthr_pkg::EM_RAM));
  end

  always_comb begin
    unique case (uc.jc)
      dthr_pkg::JC_NEVER:     jc_true = 1'b0;
      dthr_pkg::JC_ALWAYS:    jc_true = 1'b1;
      dthr_pkg::JC_FLUSH:     jc_true = in_valid && (delim_in || in_last);
      dthr_pkg::JC_EMPTY:     jc_true = empty;
      dthr_pkg::JC_NUMERIC:   jc_true = numeric_r;
      dthr_pkg::JC_TEXT_END:  jc_true = text_end;
      dthr_pkg::JC_HEX_START: jc_true = hex_start;
      dthr_pkg::JC_NIB_END:   jc_true = nib_zero;
      default:                jc_true = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt        = pc_r;
    len_nxt       = len_r;
    alld_nxt      = alld_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    first_nxt     = first_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    numeric_nxt   = numeric_r;
    sh_nxt        = sh_r;
    nib_nxt       = nib_r;
    rd_idx_nxt    = rd_idx_r;
    ram_we        = 1'b0;
    ram_waddr     = len_r[AW-1:0];
    ram_re        = 1'b0;
    ram_raddr     = rd_idx_r[AW-1:0];
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_vc_nxt    = out_vc_r;
    out_last_nxt  = out_last_r;
    out_trunc_nxt = out_trunc_r;

    if (go) begin
      if (jc_true) begin
        pc_nxt = uc.tgt;
      end else if (!uc.hold) begin
        pc_nxt = pc_r + 4'd1;
      end

      if (emit_en) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = em_char;
        out_vc_nxt    = em_vc;
        out_last_nxt  = em_last;
        out_trunc_nxt = em_trunc;
      end

      if (uc.em == dthr_pkg::EM_SPACE) begin
        first_nxt = 1'b0;
      end

      unique case (uc.op)
        dthr_pkg::OP_ACCEPT: begin
          if (in_fire) begin
            last_nxt = in_last;
            if (!delim_in) begin
              if (len_r < LEN_W'(MAX_WORD)) begin
                ram_we  = 1'b1;
                len_nxt = len_r + LEN_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
              if (empty && !ovf_r && (in_char == dthr_pkg::CH_MINUS)) begin
                neg_nxt = 1'b1;
              end else if ((in_char >= dthr_pkg::CH_ZERO) &&
                           (in_char <= dthr_pkg::CH_NINE)) begin
                acc_nxt = (acc_r << 3) + (acc_r << 1) +
                          {{(VALUE_BITS-4){1'b0}}, in_char[3:0]};
              end else begin
                alld_nxt = 1'b0;
              end
            end
          end
        end
        dthr_pkg::OP_PREP: begin
          numeric_nxt = alld_r && (len_r > LEN_W'(neg_r));
          sh_nxt      = '0;
          sh_nxt[VALUE_BITS-1:0] = acc_r;
          nib_nxt     = NIB_W'(NIBS - 1);
          rd_idx_nxt  = '0;
        end
        dthr_pkg::OP_READ: begin
          ram_re     = 1'b1;
          rd_idx_nxt = rd_idx_r + LEN_W'(1);
        end
        dthr_pkg::OP_TEXT: begin
          if (!text_end) begin
            ram_re     = 1'b1;
            rd_idx_nxt = rd_idx_r + LEN_W'(1);
          end
        end
        dthr_pkg::OP_SKIP: begin
          if (!hex_start) begin
            sh_nxt  = {sh_r[SH_W-5:0], 4'h0};
            nib_nxt = nib_r - NIB_W'(1);
          end
        end
        dthr_pkg::OP_DIGIT: begin
          if (!nib_zero) begin
            sh_nxt  = {sh_r[SH_W-5:0], 4'h0};
            nib_nxt = nib_r - NIB_W'(1);
          end
        end
        dthr_pkg::OP_FIN: begin
          len_nxt  = '0;
          alld_nxt = 1'b1;
          neg_nxt  = 1'b0;
          acc_nxt  = '0;
          ovf_nxt  = 1'b0;
          if (last_r) begin
            first_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= dthr_pkg::PC_IDLE;
      len_r       <= '0;
      alld_r      <= 1'b1;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      first_r     <= 1'b1;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      len_r       <= len_nxt;
      alld_r      <= alld_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      first_r     <= first_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    numeric_r   <= numeric_nxt;
    sh_r        <= sh_nxt;
    nib_r       <= nib_nxt;
    rd_idx_r    <= rd_idx_nxt;
    out_char_r  <= out_char_nxt;
    out_vc_r    <= out_vc_nxt;
    out_last_r  <= out_last_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_char           = out_char_r;
  assign out_valid_char     = out_vc_r;
  assign out_last           = out_last_r;
  assign out_word_truncated = out_trunc_r;

  `DTHR_ASSERT_IMP(a_len_bound, 1'b1, len_r <= LEN_W'(MAX_WORD), "word length past buffer")
  `DTHR_ASSERT_IMP(a_rd_idx, pc_r == dthr_pkg::PC_TEM,
    (rd_idx_r != '0) && (rd_idx_r <= len_r), "buffer read index out of word")
  `DTHR_ASSERT_NXT(a_last_end, go && emit_en && em_last,
    (pc_r == dthr_pkg::PC_FIN) || (pc_r == dthr_pkg::PC_IDLE), "line end not followed by finish")
  `DTHR_ASSERT_NXT(a_line_reset, go && (uc.op == dthr_pkg::OP_FIN) && last_r,
    first_r && (len_r == '0) && (pc_r == dthr_pkg::PC_IDLE), "line state not cleared")

endmodule
